FILE: src/dhf_pkg.sv
package dhf_pkg;

  // Pixel and window geometry
  localparam int unsigned DEPTH_W       = 16;
  localparam int unsigned NB_SLOTS      = 24;
  localparam int unsigned WIN           = 5;
  localparam int unsigned CENTER_IDX    = 12;
  localparam int unsigned LANES         = 4;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned MIN_DIM       = 5;

  // Register fields
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned ROW_W    = 11;
  localparam int unsigned TH_IN_W  = 4;
  localparam int unsigned TH_OUT_W = 5;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [DIM_W-1:0]    WIDTH_RST    = 11'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST   = 11'd480;
  localparam logic [TH_IN_W-1:0]  INNER_TH_RST = 4'd2;
  localparam logic [TH_OUT_W-1:0] OUTER_TH_RST = 5'd5;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_INNER_TH = 2'd2,
    REG_OUTER_TH = 2'd3
  } reg_idx_e;

  // Neighborhood handed to the mode unit
  typedef struct packed {
    logic [NB_SLOTS-1:0][DEPTH_W-1:0] vals;
    logic [NB_SLOTS-1:0]              mask;
    logic [DEPTH_W-1:0]               center;
    logic                             fill;
    logic                             frame_end;
  } mode_req_t;

endpackage

FILE: src/dhf_line_mem.sv
module dhf_line_mem #(
  parameter int unsigned DEPTH = dhf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                            clk_i,
  input  logic                                            en_i,
  input  logic [$clog2(DEPTH)-1:0]                        addr_i,
  input  logic [1:0]                                      lane_i,
  input  logic [dhf_pkg::DEPTH_W-1:0]                     wdata_i,
  output logic [dhf_pkg::LANES-1:0][dhf_pkg::DEPTH_W-1:0] rdata_o
);

  // One word per column, one lane per buffered row
  logic [dhf_pkg::LANES-1:0][dhf_pkg::DEPTH_W-1:0] mem_q [DEPTH];
  logic [dhf_pkg::LANES-1:0][dhf_pkg::DEPTH_W-1:0] rdata_q;

  // Read-first: the read returns the column before this write
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q               <= mem_q[addr_i];
      mem_q[addr_i][lane_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dhf_mode_unit.sv
module dhf_mode_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  dhf_pkg::mode_req_t          req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [dhf_pkg::DEPTH_W-1:0] depth_o,
  output logic                        frame_end_o
);

  localparam int unsigned NODES = 63;
  localparam int unsigned LEAF0 = 31;

  logic                      v3_q, v4_q, v5_q;
  logic                      rdy3, rdy4, rdy5;
  dhf_pkg::mode_req_t        req3_q;

  logic [dhf_pkg::NB_SLOTS-1:0][dhf_pkg::CNT_W-1:0]   cnt_d, cnt4_q;
  logic [dhf_pkg::NB_SLOTS-1:0][dhf_pkg::DEPTH_W-1:0] vals4_q;
  logic [dhf_pkg::DEPTH_W-1:0] center4_q;
  logic                        fill4_q, fe4_q;

  logic [dhf_pkg::DEPTH_W-1:0] depth5_q, depth5_d;
  logic                        fe5_q;

  logic [dhf_pkg::CNT_W-1:0]   t_cnt [NODES];
  logic [dhf_pkg::DEPTH_W-1:0] t_val [NODES];

  assign rdy5        = !v5_q || res_ready_i;
  assign rdy4        = !v4_q || rdy5;
  assign rdy3        = !v3_q || rdy4;
  assign req_ready_o = rdy3;

  // Stage 3: capture neighborhood
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && req_valid_i) begin
      req3_q <= req_i;
    end
  end

  // Occurrence count of each present neighbor among the present ones
  always_comb begin
    for (int i = 0; i < dhf_pkg::NB_SLOTS; i++) begin
      cnt_d[i] = '0;
      for (int b = 0; b < dhf_pkg::NB_SLOTS; b++) begin
        if (req3_q.mask[i] && req3_q.mask[b] && (req3_q.vals[b] == req3_q.vals[i])) begin
          cnt_d[i] = cnt_d[i] + dhf_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Stage 4: counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      cnt4_q    <= cnt_d;
      vals4_q   <= req3_q.vals;
      center4_q <= req3_q.center;
      fill4_q   <= req3_q.fill;
      fe4_q     <= req3_q.frame_end;
    end
  end

  // Max tree; ties keep the lower slot, i.e. the first in raster order
  always_comb begin
    for (int n = 0; n < NODES; n++) begin
      t_cnt[n] = '0;
      t_val[n] = '0;
    end
    for (int i = 0; i < dhf_pkg::NB_SLOTS; i++) begin
      t_cnt[LEAF0 + i] = cnt4_q[i];
      t_val[LEAF0 + i] = vals4_q[i];
    end
    for (int n = LEAF0 - 1; n >= 0; n--) begin
      if (t_cnt[2*n+1] >= t_cnt[2*n+2]) begin
        t_cnt[n] = t_cnt[2*n+1];
        t_val[n] = t_val[2*n+1];
      end else begin
        t_cnt[n] = t_cnt[2*n+2];
        t_val[n] = t_val[2*n+2];
      end
    end
    if (center4_q != '0) begin
      depth5_d = center4_q;
    end else if (fill4_q && (t_cnt[0] != '0)) begin
      depth5_d = t_val[0];
    end else begin
      depth5_d = '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      depth5_q <= depth5_d;
      fe5_q    <= fe4_q;
    end
  end

  assign res_valid_o = v5_q;
  assign depth_o     = depth5_q;
  assign frame_end_o = fe5_q;

endmodule

FILE: src/depth_hole_fill_mode_filter.sv
// Depth hole filler, 5x5 mode filter over four line buffers.
// Throughput: one pixel or flush request per cycle unless the output stalls;
//   a request that advances the position takes one read, one lane write of
//   the single-port line memory. The request completing a window (two rows,
//   two columns after its pixel) flows via stage 1, window, stages 3 to 5.
// Reset: registers take defaults, position and window clear, line memory not.
module depth_hole_fill_mode_filter #(
  parameter int unsigned MAX_WIDTH = dhf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dhf_pkg::DEPTH_W-1:0]   s_tdata,   // [15:0] depth_in
  input  logic                          s_tuser,   // [0] op (1: flush)
  // stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dhf_pkg::DEPTH_W-1:0]   m_tdata,   // [15:0] depth_out
  output logic                          m_tlast,   // frame_end
  // config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhf_pkg::PADDR_W-1:0]   paddr,
  input  logic [dhf_pkg::PDATA_W-1:0]   pwdata,
  output logic [dhf_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = CW + 1;
  localparam int unsigned RW   = dhf_pkg::ROW_W;
  localparam int unsigned DW   = dhf_pkg::DEPTH_W;
  localparam int unsigned SW   = $clog2(dhf_pkg::NB_SLOTS);

  // Config registers
  logic [dhf_pkg::DIM_W-1:0]    width_q, height_q;
  logic [dhf_pkg::TH_IN_W-1:0]  inner_th_q;
  logic [dhf_pkg::TH_OUT_W-1:0] outer_th_q;
  logic                         cfg_wr;
  dhf_pkg::reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = dhf_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= dhf_pkg::WIDTH_RST;
      height_q   <= dhf_pkg::HEIGHT_RST;
      inner_th_q <= dhf_pkg::INNER_TH_RST;
      outer_th_q <= dhf_pkg::OUTER_TH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dhf_pkg::REG_WIDTH:    width_q    <= pwdata[dhf_pkg::DIM_W-1:0];
        dhf_pkg::REG_HEIGHT:   height_q   <= pwdata[dhf_pkg::DIM_W-1:0];
        dhf_pkg::REG_INNER_TH: inner_th_q <= pwdata[dhf_pkg::TH_IN_W-1:0];
        dhf_pkg::REG_OUTER_TH: outer_th_q <= pwdata[dhf_pkg::TH_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dhf_pkg::REG_WIDTH:    prdata = dhf_pkg::PDATA_W'(width_q);
      dhf_pkg::REG_HEIGHT:   prdata = dhf_pkg::PDATA_W'(height_q);
      dhf_pkg::REG_INNER_TH: prdata = dhf_pkg::PDATA_W'(inner_th_q);
      dhf_pkg::REG_OUTER_TH: prdata = dhf_pkg::PDATA_W'(outer_th_q);
      default:               prdata = '0;
    endcase
  end

  // Clamped frame size
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  always_comb begin
    if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (width_q < dhf_pkg::DIM_W'(dhf_pkg::MIN_DIM)) begin
      w_eff = WW'(dhf_pkg::MIN_DIM);
    end else begin
      w_eff = WW'(width_q);
    end
    if (32'(height_q) > dhf_pkg::MAX_HEIGHT) begin
      h_eff = RW'(dhf_pkg::MAX_HEIGHT);
    end else if (height_q < dhf_pkg::DIM_W'(dhf_pkg::MIN_DIM)) begin
      h_eff = RW'(dhf_pkg::MIN_DIM);
    end else begin
      h_eff = RW'(height_q);
    end
  end

  // Input position and request decode
  logic [CW-1:0] col_q, col_d, c0, cc;
  logic [RW-1:0] row_q, row_d, r0;
  logic [RW:0]   rs;
  logic [WW-1:0] c1;
  logic          step, emit, fe;
  logic [DW-1:0] pix;
  logic          accept, mem_en;

  always_comb begin
    c0   = col_q;
    r0   = row_q;
    if ({1'b0, c0} >= w_eff) begin
      c0 = '0;
      r0 = r0 + RW'(1);
    end
    if (r0 > h_eff + RW'(2)) begin
      r0 = '0;
      c0 = '0;
    end
    step = 1'b1;
    pix  = s_tdata;
    if (!s_tuser) begin
      // a pixel during drain starts a new frame
      if (r0 >= h_eff) begin
        r0 = '0;
        c0 = '0;
      end
    end else begin
      pix = '0;
      if (r0 < h_eff) begin
        step = 1'b0;
      end
    end
    // window center position
    if (c0 >= CW'(2)) begin
      rs = {1'b0, r0} - (RW+1)'(2);
      cc = c0 - CW'(2);
    end else begin
      rs = {1'b0, r0} - (RW+1)'(3);
      cc = CW'({1'b0, c0} + w_eff - WW'(2));
    end
    emit = step && !rs[RW] && (rs[RW-1:0] < h_eff);
    fe   = emit && (rs[RW-1:0] == h_eff - RW'(1)) && ({1'b0, cc} == w_eff - WW'(1));
    c1   = {1'b0, c0} + WW'(1);
    if (!step) begin
      col_d = c0;
      row_d = r0;
    end else if (fe) begin
      col_d = '0;
      row_d = '0;
    end else if (c1 >= w_eff) begin
      col_d = '0;
      row_d = r0 + RW'(1);
    end else begin
      col_d = c1[CW-1:0];
      row_d = r0;
    end
  end

  assign accept = s_tvalid && s_tready;
  assign mem_en = accept && step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line buffers
  logic [dhf_pkg::LANES-1:0][DW-1:0] rdata;

  dhf_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .addr_i  (c0),
    .lane_i  (r0[1:0]),
    .wdata_i (pix),
    .rdata_o (rdata)
  );

  // Stage 1: waits for the memory read
  logic          v1_q, v2_q, ready1, ready2, mu_ready, shift;
  logic [DW-1:0] s1_pix_q;
  logic [1:0]    s1_lane_q;
  logic          s1_emit_q, s1_fe_q;
  logic [RW-1:0] s1_r_q;
  logic [CW-1:0] s1_c_q;

  assign ready2   = !v2_q || mu_ready;
  assign ready1   = !v1_q || ready2;
  assign s_tready = ready1;
  assign shift    = v1_q && ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ready1) begin
      v1_q <= mem_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      s1_pix_q  <= pix;
      s1_lane_q <= r0[1:0];
      s1_emit_q <= emit;
      s1_fe_q   <= fe;
      s1_r_q    <= rs[RW-1:0];
      s1_c_q    <= cc;
    end
  end

  // Stage 2: 5x5 window, shifted one column per request
  logic [DW-1:0] win_q [dhf_pkg::WIN][dhf_pkg::WIN];
  logic [DW-1:0] colv  [dhf_pkg::WIN];
  logic [RW-1:0] s2_r_q;
  logic [CW-1:0] s2_c_q;
  logic          s2_fe_q;

  always_comb begin
    for (int j = 0; j < dhf_pkg::LANES; j++) begin
      colv[j] = rdata[2'(s1_lane_q + 2'(j))];
    end
    colv[dhf_pkg::WIN-1] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      for (int j = 0; j < dhf_pkg::WIN; j++) begin
        for (int k = 0; k < dhf_pkg::WIN; k++) begin
          win_q[j][k] <= '0;
        end
      end
    end else if (ready2) begin
      v2_q <= shift && s1_emit_q;
      if (shift) begin
        for (int j = 0; j < dhf_pkg::WIN; j++) begin
          for (int k = 0; k < dhf_pkg::WIN - 1; k++) begin
            win_q[j][k] <= win_q[j][k+1];
          end
          win_q[j][dhf_pkg::WIN-1] <= colv[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift && ready2) begin
      s2_r_q  <= s1_r_q;
      s2_c_q  <= s1_c_q;
      s2_fe_q <= s1_fe_q;
    end
  end

  // In-frame neighbors and ring counts
  dhf_pkg::mode_req_t       req;
  logic [dhf_pkg::WIN-1:0]  row_ok, col_ok;
  logic [3:0]               inner_cnt;
  logic [4:0]               outer_cnt;
  logic                     present;
  logic [SW-1:0]            idx;

  always_comb begin
    inner_cnt = '0;
    outer_cnt = '0;
    present   = 1'b0;
    idx       = '0;
    req       = '0;
    for (int j = 0; j < dhf_pkg::WIN; j++) begin
      if (j < 2) begin
        row_ok[j] = s2_r_q >= RW'(2 - j);
        col_ok[j] = s2_c_q >= CW'(2 - j);
      end else if (j == 2) begin
        row_ok[j] = 1'b1;
        col_ok[j] = 1'b1;
      end else begin
        row_ok[j] = (s2_r_q + RW'(j - 2)) < h_eff;
        col_ok[j] = ({1'b0, s2_c_q} + WW'(j - 2)) < w_eff;
      end
    end
    for (int j = 0; j < dhf_pkg::WIN; j++) begin
      for (int k = 0; k < dhf_pkg::WIN; k++) begin
        if (j * dhf_pkg::WIN + k != dhf_pkg::CENTER_IDX) begin
          // slots skip the center
          if (j * dhf_pkg::WIN + k > dhf_pkg::CENTER_IDX) begin
            idx = SW'(j * dhf_pkg::WIN + k - 1);
          end else begin
            idx = SW'(j * dhf_pkg::WIN + k);
          end
          present        = row_ok[j] && col_ok[k] && (win_q[j][k] != '0);
          req.vals[idx]  = win_q[j][k];
          req.mask[idx]  = present;
          if (j >= 1 && j <= 3 && k >= 1 && k <= 3) begin
            inner_cnt = inner_cnt + 4'(present);
          end else begin
            outer_cnt = outer_cnt + 5'(present);
          end
        end
      end
    end
    req.center    = win_q[2][2];
    req.fill      = (inner_cnt >= inner_th_q) || (outer_cnt >= outer_th_q);
    req.frame_end = s2_fe_q;
  end

  // Mode search and output register
  dhf_mode_unit u_mode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (v2_q),
    .req_ready_o (mu_ready),
    .req_i       (req),
    .res_valid_o (m_tvalid),
    .res_ready_i (m_tready),
    .depth_o     (m_tdata),
    .frame_end_o (m_tlast)
  );

  // Checks
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_wr) |=> ({1'b0, col_q} < w_eff))
    else $error("input column not below frame width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !cfg_wr) |=> (row_q <= h_eff + RW'(3)))
    else $error("input row beyond drain range");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v1_q && !v2_q) |-> s_tready)
    else $error("input stalled with empty front stages");

endmodule

FILE: tb/sv/depth_hole_fill_mode_filter_tb.sv
module depth_hole_fill_mode_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW          = dhf_pkg::DEPTH_W;
  localparam int AW          = dhf_pkg::PADDR_W;
  localparam int PW          = dhf_pkg::PDATA_W;
  localparam int MAXW        = dhf_pkg::MAX_WIDTH_DEF;
  localparam int MAXH        = dhf_pkg::MAX_HEIGHT;
  localparam int NSLOT       = dhf_pkg::NB_SLOTS;
  localparam int WD_LIMIT    = 5000;
  localparam int RAND_TARGET = 1160;

  typedef struct {
    logic [DW-1:0] depth;
    logic          last;
  } pix_out_t;

  typedef struct {
    logic          op;
    logic [DW-1:0] depth;
  } pix_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;   // [15:0] depth_in
  logic s_tuser = 1'b0;          // [0] op (1: flush)
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DW-1:0] m_tdata;        // [15:0] depth_out
  logic m_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [PW-1:0] pwdata = '0;
  logic [PW-1:0] prdata;
  logic pready;

  depth_hole_fill_mode_filter dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the filter
  logic [DW-1:0] line_mem [4*MAXW];
  logic [DW-1:0] win [5][5];
  int col_in, row_in;
  logic [dhf_pkg::DIM_W-1:0]    width_reg  = dhf_pkg::WIDTH_RST;
  logic [dhf_pkg::DIM_W-1:0]    height_reg = dhf_pkg::HEIGHT_RST;
  logic [dhf_pkg::TH_IN_W-1:0]  inner_reg  = dhf_pkg::INNER_TH_RST;
  logic [dhf_pkg::TH_OUT_W-1:0] outer_reg  = dhf_pkg::OUTER_TH_RST;

  pix_out_t filled_q[$];
  int  errors = 0;
  int  rand_items = 0;
  bit  frame_done;
  bit  no_idle;
  int  idle_cycles = 0;
  bit  s_acc, m_acc;

  // Mode of nonzero in-frame neighbours, gated by ring counts
  function automatic logic [DW-1:0] window_mode(int r, int c, int w, int h);
    logic [DW-1:0] vals [NSLOT];
    logic [DW-1:0] best;
    int n, inner, outer, y, x, cnt, best_cnt;
    n = 0; inner = 0; outer = 0; best = '0; best_cnt = 0;
    for (int j = 0; j < 5; j++) begin
      for (int k = 0; k < 5; k++) begin
        y = r - 2 + j;
        x = c - 2 + k;
        if (!(j == 2 && k == 2) && y >= 0 && y < h && x >= 0 && x < w &&
            win[j][k] != 0) begin
          vals[n] = win[j][k];
          n++;
          if (j >= 1 && j <= 3 && k >= 1 && k <= 3) inner++;
          else outer++;
        end
      end
    end
    if (inner < inner_reg && outer < outer_reg) return '0;
    for (int a = 0; a < n; a++) begin
      cnt = 0;
      for (int b = 0; b < n; b++) if (vals[b] == vals[a]) cnt++;
      if (cnt > best_cnt) begin
        best_cnt = cnt;
        best = vals[a];
      end
    end
    return best;
  endfunction

  // Advance the shadow state by one accepted request
  task automatic predict_fill(pix_req_t rq);
    int w, h, r, c;
    logic [DW-1:0] v;
    logic [DW-1:0] colv [5];
    pix_out_t o;
    w = width_reg;  h = height_reg;
    if (w < 5) w = 5;
    if (w > MAXW) w = MAXW;
    if (h < 5) h = 5;
    if (h > MAXH) h = MAXH;
    if (col_in >= w) begin col_in = 0; row_in++; end
    if (row_in > h + 2) begin row_in = 0; col_in = 0; end
    if (!rq.op) begin
      if (row_in >= h) begin row_in = 0; col_in = 0; end
      v = rq.depth;
    end else begin
      if (row_in < h) return;
      v = '0;
    end
    for (int j = 0; j < 4; j++) colv[j] = line_mem[((row_in + j) & 3) * MAXW + col_in];
    colv[4] = v;
    line_mem[(row_in & 3) * MAXW + col_in] = v;
    for (int j = 0; j < 5; j++) begin
      for (int k = 0; k < 4; k++) win[j][k] = win[j][k+1];
      win[j][4] = colv[j];
    end
    if (col_in >= 2) begin
      r = row_in - 2; c = col_in - 2;
    end else begin
      r = row_in - 3; c = col_in + w - 2;
    end
    col_in++;
    if (col_in >= w) begin col_in = 0; row_in++; end
    if (r < 0 || r >= h) return;
    o.depth = win[2][2];
    if (o.depth == 0) o.depth = window_mode(r, c, w, h);
    o.last = 1'b0;
    if (r == h - 1 && c == w - 1) begin
      o.last = 1'b1;
      row_in = 0;
      col_in = 0;
      frame_done = 1'b1;
    end
    filled_q.insert(filled_q.size(), o);
  endtask

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Drive one request and wait for its acceptance
  task automatic send_req(pix_req_t rq);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq.op;
    s_tdata  <= rq.depth;
    do @(posedge clk_i); while (!s_tready);
    predict_fill(rq);
  endtask

  task automatic apb_xfer(bit wr, dhf_pkg::reg_idx_e idx, logic [PW-1:0] wd,
                          output logic [PW-1:0] rd);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr;
    paddr <= AW'({idx, 2'b00}); pwdata <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_check(dhf_pkg::reg_idx_e idx, logic [PW-1:0] wd, logic [PW-1:0] mask);
    logic [PW-1:0] rd;
    apb_xfer(1'b1, idx, wd, rd);
    apb_xfer(1'b0, idx, '0, rd);
    if ((rd & mask) !== (wd & mask)) begin
      $error("prdata reg %s: expected %0h, got %0h", idx.name(), wd & mask, rd & mask);
      errors++;
    end
  endtask

  // Drain, settle, then program all four registers
  task automatic set_config(int w, int h, int ti, int to);
    s_tvalid <= 1'b0;
    while (filled_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_check(dhf_pkg::REG_WIDTH, w, 32'h7FF);
    write_check(dhf_pkg::REG_HEIGHT, h, 32'h7FF);
    write_check(dhf_pkg::REG_INNER_TH, ti, 32'hF);
    write_check(dhf_pkg::REG_OUTER_TH, to, 32'h1F);
    width_reg = w; height_reg = h; inner_reg = ti; outer_reg = to;
  endtask

  // Run requests until the shadow model closes a frame
  task automatic run_frame(bit counted);
    logic [DW-1:0] pal [4];
    pix_req_t rq;
    bit abandon;
    int hh, ww;
    for (int i = 0; i < 4; i++) pal[i] = DW'($urandom);
    abandon = ($urandom_range(0, 5) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    hh = (height_reg < 5) ? 5 : (height_reg > MAXH ? MAXH : height_reg);
    ww = (width_reg < 5) ? 5 : (width_reg > MAXW ? MAXW : width_reg);
    frame_done = 1'b0;
    while (!frame_done) begin
      rq.depth = DW'($urandom);
      if ($urandom_range(0, 9) < 4) rq.depth = '0;
      else if ($urandom_range(0, 3) != 0) rq.depth = pal[$urandom_range(0, 3)];
      if (row_in < hh && !(row_in == hh - 1 && col_in >= ww)) begin
        rq.op = ($urandom_range(0, 39) == 0);
      end else if (abandon && $urandom_range(0, 20) == 0) begin
        rq.op = 1'b0;
        abandon = 1'b0;
      end else begin
        rq.op = 1'b1;
      end
      send_req(rq);
      if (counted) rand_items++;
    end
  endtask

  // Output side: random stalls, compare against the oldest prediction
  always @(posedge clk_i) begin
    pix_out_t e;
    int p;
    s_acc = s_tvalid && s_tready;
    m_acc = m_tvalid && m_tready;
    if (rst_ni && m_acc) begin
      if (filled_q.size() == 0) begin
        $error("unexpected result depth_out %0h", m_tdata);
        errors++;
      end else begin
        e = filled_q[0];
        filled_q.delete(0);
        if (m_tdata !== e.depth) begin
          $error("depth_out: expected %0h, got %0h", e.depth, m_tdata);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("frame_end: expected %0b, got %0b", e.last, m_tlast);
          errors++;
        end
      end
    end
    p = $urandom_range(0, 99);
    m_tready <= no_idle || p < 70 || (p < 99 && $urandom_range(0, 1) == 0);
    // watchdog on lack of progress
    if (s_acc || m_acc || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("[depth_hole_fill_mode_filter] ERROR");
      $finish;
    end
  end

  // Directed requests: a flush inside the frame, depth extremes, ties
  pix_req_t directed [25] = '{
    '{1'b1, 16'h0000}, '{1'b0, 16'hFFFF}, '{1'b0, 16'h0000}, '{1'b0, 16'h0001},
    '{1'b0, 16'h8000}, '{1'b0, 16'h0000}, '{1'b0, 16'h0000}, '{1'b0, 16'hFFFF},
    '{1'b0, 16'h0001}, '{1'b0, 16'h0000}, '{1'b0, 16'h0001}, '{1'b0, 16'h0000},
    '{1'b0, 16'h0000}, '{1'b0, 16'h0000}, '{1'b0, 16'h8000}, '{1'b0, 16'h8000},
    '{1'b0, 16'h0000}, '{1'b0, 16'h0001}, '{1'b0, 16'h0000}, '{1'b0, 16'hFFFF},
    '{1'b0, 16'h5555}, '{1'b0, 16'hAAAA}, '{1'b0, 16'h0000}, '{1'b0, 16'h0000},
    '{1'b1, 16'h0000}
  };

  initial begin
    for (int i = 0; i < 4*MAXW; i++) line_mem[i] = '0;
    for (int j = 0; j < 5; j++) for (int k = 0; k < 5; k++) win[j][k] = '0;
    col_in = 0; row_in = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(5, 5, 2, 5);
    no_idle = 1'b0;
    foreach (directed[i]) send_req(directed[i]);
    run_frame(1'b0);

    // extremes and clamped values
    set_config(3, 9, 0, 0);
    run_frame(1'b0);
    set_config(2047, 2047, 15, 31);
    set_config(12, 5, 1, 16);
    run_frame(1'b0);

    while (rand_items < RAND_TARGET) begin
      set_config($urandom_range(5, 12), $urandom_range(5, 9),
                 $urandom_range(0, 15), $urandom_range(0, 31));
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
    end

    s_tvalid <= 1'b0;
    while (filled_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("[depth_hole_fill_mode_filter] OK");
    else $display("[depth_hole_fill_mode_filter] ERROR");
    $finish;
  end

endmodule

FILE: depth_hole_fill_mode_filter.f
src/dhf_pkg.sv
src/dhf_line_mem.sv
src/dhf_mode_unit.sv
src/depth_hole_fill_mode_filter.sv
tb/sv/depth_hole_fill_mode_filter_tb.sv
